/* rtl/core/qpe_pkg.sv */
// Shared types, character codes and helpers for the query parameter decoder.
package qpe_pkg;

  localparam int unsigned NameRegBytes = 16;
  localparam int unsigned MaxResults   = 4;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharAmp     = 8'h26;
  localparam logic [7:0] CharEq      = 8'h3D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [3:0] HexAlphaOfs = 4'h9;  // low nibble of 'A'/'a' is 1, so 1 + 9 = 0xa

  typedef enum logic [1:0] {
    REG_NAME_LOW,
    REG_NAME_HIGH,
    REG_NAME_LENGTH,
    REG_MAX_LENGTH
  } cfg_reg_e;

  typedef struct packed {
    logic [8*NameRegBytes-1:0] name_bytes;
    logic [4:0]                name_length;
    logic [12:0]               max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        found;
    logic [12:0] value_length;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] slot;
    logic    [2:0]            count;
  } bundle_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, 4'(b[3:0] + HexAlphaOfs)};
    end
    return r;
  endfunction

endpackage

/* rtl/core/qpe_if.sv */
// Stream interfaces for query bytes in and decoded results out.
interface qpe_query_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       end_of_query;

  modport source (output valid, output query_byte, output end_of_query, input ready);
  modport sink (input valid, input query_byte, input end_of_query, output ready);
endinterface

interface qpe_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        found;
  logic [12:0] value_length;
  logic        last;

  modport source (output valid, output data_byte, output data_valid, output found,
                  output value_length, output last, input ready);
  modport sink (input valid, input data_byte, input data_valid, input found,
                input value_length, input last, output ready);
endinterface

/* rtl/core/qpe_cfg_regs.sv */
// Configuration register bank: parameter name, name length and value limit.
module qpe_cfg_regs import qpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_bytes  <= '0;
      cfg_q.name_length <= 5'd1;
      cfg_q.max_length  <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_NAME_LOW:    cfg_q.name_bytes[63:0]   <= cfg_data_i;
        REG_NAME_HIGH:   cfg_q.name_bytes[127:64] <= cfg_data_i;
        REG_NAME_LENGTH: cfg_q.name_length        <= cfg_data_i[4:0];
        REG_MAX_LENGTH:  cfg_q.max_length         <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/qpe_step.sv */
// Per-byte scanner: name match, segment skip and value decode state, result bundle.
module qpe_step import qpe_pkg::*; #(
  parameter int unsigned NAME_BYTES = 16,
  parameter int unsigned VALUE_MAX  = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] query_byte_i,
  input  logic       end_of_query_i,
  input  cfg_t       cfg_i,
  output bundle_t    bundle_o
);

  localparam int unsigned PosW    = $clog2(NAME_BYTES + 1);
  localparam int unsigned KeptMax = (VALUE_MAX < 8191) ? VALUE_MAX : 8191;
  localparam int unsigned KeptW   = $clog2(KeptMax + 1);

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_SKIP,
    MODE_VALUE,
    MODE_DONE
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [1:0]       pend_q, pend_d;
  logic [7:0]       held_q, held_d;
  logic [KeptW-1:0] kept_q, kept_d, kept_base;
  logic             found_q, found_d;

  logic [7:0]  cand [0:3];
  logic [1:0]  cn;
  logic        fall;
  logic [4:0]  hb, hh;
  logic [6:0]  pos7, nlen7;
  logic [7:0]  name_b;
  logic [16:0] lim, room, kept_sum;
  logic [1:0]  keep_n;
  bundle_t     bundle;

  assign hb    = hex_of(query_byte_i);
  assign hh    = hex_of(held_q);
  assign pos7  = 7'(pos_q);
  assign nlen7 = (7'(cfg_i.name_length) > 7'(NAME_BYTES)) ? 7'(NAME_BYTES)
                                                           : 7'(cfg_i.name_length);
  // only the register-held bytes are non-zero
  assign name_b = (pos7 < 7'(NameRegBytes)) ? cfg_i.name_bytes[8*pos7[3:0] +: 8] : 8'd0;
  assign lim    = (17'(cfg_i.max_length) > 17'(VALUE_MAX)) ? 17'(VALUE_MAX)
                                                            : 17'(cfg_i.max_length);

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    held_d    = held_q;
    found_d   = found_q;
    kept_base = kept_q;
    cand[0]   = 8'd0;
    cand[1]   = 8'd0;
    cand[2]   = 8'd0;
    cand[3]   = 8'd0;
    cn        = 2'd0;
    fall      = 1'b0;

    case (mode_q)
      MODE_MATCH: begin
        if (query_byte_i == CharAmp) begin
          pos_d = '0;
        end else if (pos7 < nlen7) begin
          if (query_byte_i == name_b) pos_d = pos_q + 1'b1;
          else mode_d = MODE_SKIP;
        end else if (query_byte_i == CharEq) begin
          mode_d    = MODE_VALUE;
          found_d   = 1'b1;
          kept_base = '0;
        end else begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (query_byte_i == CharAmp) begin
          mode_d = MODE_MATCH;
          pos_d  = '0;
        end
      end
      MODE_VALUE: begin
        case (pend_q)
          2'd1: begin
            if (hb[4]) begin
              held_d = query_byte_i;
              pend_d = 2'd2;
            end else begin
              cand[cn] = CharPercent; cn = cn + 2'd1;
              pend_d = 2'd0;
              held_d = 8'd0;
              fall   = 1'b1;
            end
          end
          2'd2: begin
            if (hb[4]) begin
              cand[cn] = {hh[3:0], hb[3:0]}; cn = cn + 2'd1;
            end else begin
              cand[cn] = CharPercent; cn = cn + 2'd1;
              cand[cn] = held_q;      cn = cn + 2'd1;
              fall = 1'b1;
            end
            pend_d = 2'd0;
            held_d = 8'd0;
          end
          default: fall = 1'b1;
        endcase
        if (fall) begin
          if (query_byte_i == CharPercent) begin
            pend_d = 2'd1;
          end else if (query_byte_i == CharAmp) begin
            mode_d = MODE_DONE;
          end else if (query_byte_i == CharPlus) begin
            cand[cn] = CharSpace; cn = cn + 2'd1;
          end else begin
            cand[cn] = query_byte_i; cn = cn + 2'd1;
          end
        end
      end
      default: ;
    endcase

    // unfinished escape goes out literally at end of query
    if (end_of_query_i && mode_d == MODE_VALUE) begin
      if (pend_d != 2'd0) begin
        cand[cn] = CharPercent; cn = cn + 2'd1;
      end
      if (pend_d == 2'd2) begin
        cand[cn] = held_d; cn = cn + 2'd1;
      end
    end
  end

  assign room     = (lim > 17'(kept_base)) ? (lim - 17'(kept_base)) : 17'd0;
  assign keep_n   = (17'(cn) < room) ? cn : room[1:0];
  assign kept_sum = 17'(kept_base) + 17'(keep_n);
  assign kept_d   = KeptW'(kept_sum);

  always_comb begin
    bundle = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < keep_n) begin
        bundle.slot[i].data_byte  = cand[i];
        bundle.slot[i].data_valid = 1'b1;
      end
    end
    if (end_of_query_i) begin
      bundle.slot[keep_n].found        = found_d;
      bundle.slot[keep_n].value_length = found_d ? 13'(kept_d) : 13'd0;
      bundle.slot[keep_n].last         = 1'b1;
    end
    bundle.count = 3'(keep_n) + 3'(end_of_query_i);
  end

  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MATCH;
      pos_q   <= '0;
      pend_q  <= 2'd0;
      held_q  <= 8'd0;
      kept_q  <= '0;
      found_q <= 1'b0;
    end else if (accept_i) begin
      if (end_of_query_i) begin
        mode_q  <= MODE_MATCH;
        pos_q   <= '0;
        pend_q  <= 2'd0;
        held_q  <= 8'd0;
        kept_q  <= '0;
        found_q <= 1'b0;
      end else begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        pend_q  <= pend_d;
        held_q  <= held_d;
        kept_q  <= kept_d;
        found_q <= found_d;
      end
    end
  end

endmodule

/* rtl/core/qpe_out_buf.sv */
// Result register: loads bundles of up to four results, hands out one per cycle unless stalled.
module qpe_out_buf import qpe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  input  logic    take_i,
  output logic    valid_o,
  output result_t result_o,
  output logic    can_accept_o
);

  result_t    slot_q [0:MaxResults-1];
  logic [2:0] rem_q;

  assign valid_o      = (rem_q != 3'd0);
  assign result_o     = slot_q[0];
  assign can_accept_o = (rem_q == 3'd0) || (rem_q == 3'd1 && take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else if (load_i) begin
      rem_q <= bundle_i.count;
    end else if (take_i) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxResults; i++) slot_q[i] <= bundle_i.slot[i];
    end else if (take_i) begin
      for (int i = 0; i < MaxResults - 1; i++) slot_q[i] <= slot_q[i+1];
    end
  end

endmodule

/* rtl/core/query_parameter_extract_decode.sv */
// Query parameter extractor: scans a URL query string one byte per item, picks the first
// '&' segment starting with the configured name and '=', and streams its value with '+'
// turned into space and '%XX' escapes decoded; the last byte of a query also yields a
// summary item (found flag, kept length). A byte is taken every cycle as long as each byte
// gives at most one result and the receiver is ready; a byte that gives k results (k up to
// four, escapes flushed at segment or query end plus the summary) holds the input until
// the last of them is being taken, since the output register hands out one result per cycle
// while the receiver is ready. The first result of a byte appears the cycle after the byte is
// taken. No start-up clearing pass is needed.
module query_parameter_extract_decode import qpe_pkg::*; #(
  parameter int unsigned NAME_BYTES = 16,
  parameter int unsigned VALUE_MAX  = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  qpe_query_if.sink          query_i,
  qpe_result_if.source       result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cfg_t    cfg;
  bundle_t bundle;
  result_t res;
  logic    in_acc, can_accept, take, out_valid;

  qpe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_acc        = query_i.valid && can_accept;
  assign query_i.ready = can_accept;
  assign take          = out_valid && result_o.ready;

  qpe_step #(
    .NAME_BYTES (NAME_BYTES),
    .VALUE_MAX  (VALUE_MAX)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_acc),
    .query_byte_i   (query_i.query_byte),
    .end_of_query_i (query_i.end_of_query),
    .cfg_i          (cfg),
    .bundle_o       (bundle)
  );

  qpe_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc && bundle.count != 3'd0),
    .bundle_i     (bundle),
    .take_i       (take),
    .valid_o      (out_valid),
    .result_o     (res),
    .can_accept_o (can_accept)
  );

  assign result_o.valid        = out_valid;
  assign result_o.data_byte    = res.data_byte;
  assign result_o.data_valid   = res.data_valid;
  assign result_o.found        = res.found;
  assign result_o.value_length = res.value_length;
  assign result_o.last         = res.last;

endmodule

/* rtl/core/qpe_checker.sv */
// Port-level checks on the result stream, bound to the top level.
module qpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  data_byte_i,
  input logic        data_valid_i,
  input logic        found_i,
  input logic [12:0] value_length_i,
  input logic        last_i
);

  logic [16:0] data_cnt_q;
  logic        take;

  assign take = out_valid_i && out_ready_i;

  // data items handed out since the last summary
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_cnt_q <= 17'd0;
    end else if (take && last_i) begin
      data_cnt_q <= 17'd0;
    end else if (take && data_valid_i) begin
      data_cnt_q <= data_cnt_q + 17'd1;
    end
  end

  a_len_matches_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last_i |-> 17'(value_length_i) == data_cnt_q)
    else $error("summary length differs from data items delivered");

  a_no_data_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last_i && !found_i |-> data_cnt_q == 17'd0)
    else $error("data items delivered for a query without the parameter");

  a_data_item_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && data_valid_i |-> !last_i && !found_i && value_length_i == 13'd0)
    else $error("data item carries summary fields");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({data_byte_i, data_valid_i, found_i, value_length_i, last_i}))
    else $error("stalled result item changed");

endmodule

bind query_parameter_extract_decode qpe_checker u_qpe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .data_byte_i    (result_o.data_byte),
  .data_valid_i   (result_o.data_valid),
  .found_i        (result_o.found),
  .value_length_i (result_o.value_length),
  .last_i         (result_o.last)
);
